@@ sv/sce_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sprite chunk expander package
// Shared constants, register indexes and the priority mask lookup.
// ----------------------------------------------------------------------------
package sce_pkg;

  // Default width of the chunk map address.
  localparam int unsigned MAP_ADDR_BITS_DEF = 18;

  // Register indexes of the configuration port.
  localparam logic REG_X_OFFSET = 1'b0;
  localparam logic REG_Y_OFFSET = 1'b1;

  // Commands carried by an input item.
  localparam logic CMD_MAP_WRITE = 1'b0;
  localparam logic CMD_EXPAND    = 1'b1;

  // Register reset values (10-bit two's complement).
  localparam logic [9:0] X_OFFSET_RST = 10'd48;
  localparam logic [9:0] Y_OFFSET_RST = 10'(-116);

  // Coordinates above this limit wrap to negative by one span.
  localparam logic [11:0] WRAP_LIMIT = 12'h340;
  localparam logic [11:0] WRAP_SPAN  = 12'h400;

  // Vertical bias applied to every chunk top edge.
  localparam logic [11:0] Y_BIAS = 12'd16;

  // Map code that marks an empty chunk.
  localparam logic [15:0] SKIP_CODE = 16'hffff;

  // Priority mask for each two-bit sprite priority.
  function automatic logic [15:0] prio_mask(input logic [1:0] prio);
    logic [15:0] mask;
    case (prio)
      2'd0: mask = 16'hfffc;
      2'd1: mask = 16'hfff0;
      2'd2: mask = 16'hff00;
      default: mask = 16'h0000;
    endcase
    return mask;
  endfunction

endpackage
`default_nettype wire

@@ sv/sce_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sprite chunk expander RAM
// Generic single-clock RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module sce_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     wr_en_i,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  wire logic [WIDTH-1:0]         wr_data_i,
  input  wire logic                     rd_en_i,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic      [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  // Write and registered read; the read data holds when no read is issued.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule
`default_nettype wire

@@ sv/sprite_chunk_expander_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sprite chunk expander unit
// Keeps the chunk map store and expands one sprite entry into its chunks.
// ----------------------------------------------------------------------------
//
//  Channel   Signals                                   Direction
//  -------   ---------------------------------------   ---------
//  input     in_valid_i / in_ready_o, command + words   in
//  result    out_valid_o / out_ready_i, chunk fields    out
//  config    cfg_we_i, cfg_index_i, cfg_data_i          in
//
//  A map write does not leave idle; the store is written at the input transfer.
//  An expanded entry reads one map word per cycle from the store while the
//  read pipeline is not held by a result-side stall, dim*dim words in all.
//  A tile of zero never leaves idle, so it is taken like a map write.
//  Reset clears the control state and the offset registers, not the store.
//  A result-side stall holds the read pipeline while the input stays closed.
//
module sprite_chunk_expander_unit #(
  parameter int unsigned MAP_ADDR_BITS = sce_pkg::MAP_ADDR_BITS_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Configuration port
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_index_i,
  input  wire logic [9:0]  cfg_data_i,
  // Input channel
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic        command_i,
  input  wire logic [31:0] entry_word_a_i,
  input  wire logic [31:0] entry_word_c_i,
  input  wire logic [31:0] entry_word_d_i,
  input  wire logic [17:0] map_address_i,
  input  wire logic [15:0] map_word_i,
  // Result channel
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [14:0]      chunk_code_o,
  output logic [11:0]      palette_base_o,
  output logic             mirror_x_o,
  output logic             mirror_y_o,
  output logic [11:0]      screen_x_o,
  output logic [11:0]      screen_y_o,
  output logic [6:0]       chunk_width_o,
  output logic [6:0]       chunk_height_o,
  output logic [15:0]      priority_mask_o,
  output logic             last_chunk_o
);

  import sce_pkg::*;

  localparam int unsigned MAP_DEPTH = 1 << MAP_ADDR_BITS;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  // Control state
  logic       state_q, state_d;
  logic [3:0] ch_q, ch_d;
  logic       issue_done_q, issue_done_d;
  logic       rd_vld_q, rd_vld_d;
  logic [3:0] rd_ch_q, rd_ch_d;
  logic       pend_vld_q, pend_vld_d;
  logic       out_vld_q, out_vld_d;

  // Offset registers
  logic [9:0] x_off_q, y_off_q;

  // Entry registers
  logic        dbl_q, flipx_q, flipy_q;
  logic [7:0]  zoomx_q, zoomy_q;
  logic [14:0] tile_q;
  logic [1:0]  prio_q;
  logic [6:0]  colour_q;
  logic [11:0] xb_q, yb_q;

  // Pending chunk, held until it is known whether it is the last one
  logic [14:0] pend_code_q;
  logic [11:0] pend_sx_q, pend_sy_q;
  logic [6:0]  pend_w_q, pend_h_q;

  // Output register
  logic [14:0] out_code_q;
  logic [11:0] out_pal_q;
  logic        out_mx_q, out_my_q;
  logic [11:0] out_sx_q, out_sy_q;
  logic [6:0]  out_w_q, out_h_q;
  logic [15:0] out_prio_q;
  logic        out_last_q;

  // --------------------------------------------------------------------------
  // Input decode: swap the halves of each word and unpack the entry.
  // --------------------------------------------------------------------------
  logic [31:0] a_sw, c_sw, d_sw;
  logic        in_xfer, map_wr, expand;
  logic [7:0]  zoomx_in, zoomy_in;
  logic [11:0] x_raw, y_sum, x_wrap, y_wrap, x_base;

  assign a_sw = {entry_word_a_i[15:0], entry_word_a_i[31:16]};
  assign c_sw = {entry_word_c_i[15:0], entry_word_c_i[31:16]};
  assign d_sw = {entry_word_d_i[15:0], entry_word_d_i[31:16]};

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_xfer    = in_valid_i && in_ready_o;
  assign map_wr     = in_xfer && (command_i == CMD_MAP_WRITE);
  assign expand     = in_xfer && (command_i == CMD_EXPAND) && (a_sw[14:0] != 15'd0);

  assign zoomx_in = {1'b0, a_sw[22:16]} + 8'd1;
  assign zoomy_in = {1'b0, d_sw[16:10]} + 8'd1;

  // Position: add the y offset, wrap values above the limit, subtract x offset.
  assign x_raw  = {2'b00, c_sw[9:0]};
  assign y_sum  = {2'b00, d_sw[9:0]} + {{2{y_off_q[9]}}, y_off_q};
  assign x_wrap = (x_raw > WRAP_LIMIT) ? x_raw - WRAP_SPAN : x_raw;
  assign y_wrap = (!y_sum[11] && (y_sum > WRAP_LIMIT)) ? y_sum - WRAP_SPAN : y_sum;
  assign x_base = x_wrap - {{2{x_off_q[9]}}, x_off_q};

  // --------------------------------------------------------------------------
  // Read issue: map address of the chunk at the head of the walk.
  // --------------------------------------------------------------------------
  logic [1:0]  dmask, col0, row0, px, py;
  logic [17:0] addr_sum;
  logic [3:0]  last_idx;

  assign dmask    = dbl_q ? 2'b11 : 2'b01;
  assign col0     = dbl_q ? ch_q[1:0] : {1'b0, ch_q[0]};
  assign row0     = dbl_q ? ch_q[3:2] : {1'b0, ch_q[1]};
  assign px       = flipx_q ? (col0 ^ dmask) : col0;
  assign py       = flipy_q ? (row0 ^ dmask) : row0;
  assign addr_sum = {1'b0, tile_q, 2'b00} + {16'd0, px}
                  + (dbl_q ? {14'd0, py, 2'b00} : {15'd0, py, 1'b0});
  assign last_idx = dbl_q ? 4'd15 : 4'd3;

  // --------------------------------------------------------------------------
  // Chunk map store
  // --------------------------------------------------------------------------
  logic        issue;
  logic [15:0] rd_data;

  sce_ram #(
    .WIDTH (16),
    .DEPTH (MAP_DEPTH)
  ) u_map_ram (
    .clk_i     (clk_i),
    .wr_en_i   (map_wr),
    .wr_addr_i (MAP_ADDR_BITS'(map_address_i)),
    .wr_data_i (map_word_i),
    .rd_en_i   (issue),
    .rd_addr_i (MAP_ADDR_BITS'(addr_sum)),
    .rd_data_o (rd_data)
  );

  // --------------------------------------------------------------------------
  // Read stage: scale the chunk position and size.
  // --------------------------------------------------------------------------
  logic [1:0]  col1, row1;
  logic [9:0]  mx0, mx1, my0, my1, qx0, qx1, qy0, qy1;
  logic [14:0] new_code;
  logic [11:0] new_sx, new_sy;
  logic [6:0]  new_w, new_h;

  assign col1 = dbl_q ? rd_ch_q[1:0] : {1'b0, rd_ch_q[0]};
  assign row1 = dbl_q ? rd_ch_q[3:2] : {1'b0, rd_ch_q[1]};
  assign mx0  = {8'd0, col1} * {2'b00, zoomx_q};
  assign my0  = {8'd0, row1} * {2'b00, zoomy_q};
  assign mx1  = mx0 + {2'b00, zoomx_q};
  assign my1  = my0 + {2'b00, zoomy_q};
  assign qx0  = dbl_q ? (mx0 >> 2) : (mx0 >> 1);
  assign qx1  = dbl_q ? (mx1 >> 2) : (mx1 >> 1);
  assign qy0  = dbl_q ? (my0 >> 2) : (my0 >> 1);
  assign qy1  = dbl_q ? (my1 >> 2) : (my1 >> 1);

  assign new_code = rd_data[14:0];
  assign new_sx   = xb_q + {2'b00, qx0};
  assign new_sy   = yb_q + {2'b00, qy0} - Y_BIAS;
  assign new_w    = 7'(qx1 - qx0);
  assign new_h    = 7'(qy1 - qy0);

  // --------------------------------------------------------------------------
  // Flow control of the read pipeline, pending slot and output register.
  // --------------------------------------------------------------------------
  logic out_free, skip, st1_take, st1_adv, end_cond, out_load;

  assign out_free = !out_vld_q || out_ready_i;
  assign skip     = (rd_data == SKIP_CODE);
  assign st1_take = rd_vld_q && !skip;
  assign st1_adv  = !rd_vld_q || skip || !pend_vld_q || out_free;
  assign end_cond = (state_q == ST_RUN) && issue_done_q && !rd_vld_q;
  assign issue    = (state_q == ST_RUN) && !issue_done_q && st1_adv;
  assign out_load = (st1_take && pend_vld_q && out_free)
                  || (end_cond && pend_vld_q && out_free);

  always_comb begin
    state_d      = state_q;
    ch_d         = ch_q;
    issue_done_d = issue_done_q;
    rd_ch_d      = rd_ch_q;
    rd_vld_d     = st1_adv ? issue : rd_vld_q;
    pend_vld_d   = pend_vld_q;
    out_vld_d    = out_load ? 1'b1 : (out_ready_i ? 1'b0 : out_vld_q);

    if (issue) begin
      rd_ch_d      = ch_q;
      ch_d         = ch_q + 4'd1;
      issue_done_d = (ch_q == last_idx);
    end

    // The pending slot takes each new chunk and empties at the end of the walk.
    if (st1_take && st1_adv) begin
      pend_vld_d = 1'b1;
    end else if (end_cond && pend_vld_q && out_free) begin
      pend_vld_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (expand) begin
          state_d      = ST_RUN;
          ch_d         = 4'd0;
          issue_done_d = 1'b0;
        end
      end
      ST_RUN: begin
        if (end_cond && (!pend_vld_q || out_free)) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      ch_q         <= 4'd0;
      issue_done_q <= 1'b0;
      rd_vld_q     <= 1'b0;
      rd_ch_q      <= 4'd0;
      pend_vld_q   <= 1'b0;
      out_vld_q    <= 1'b0;
      x_off_q      <= X_OFFSET_RST;
      y_off_q      <= Y_OFFSET_RST;
    end else begin
      state_q      <= state_d;
      ch_q         <= ch_d;
      issue_done_q <= issue_done_d;
      rd_vld_q     <= rd_vld_d;
      rd_ch_q      <= rd_ch_d;
      pend_vld_q   <= pend_vld_d;
      out_vld_q    <= out_vld_d;
      if (cfg_we_i && (cfg_index_i == REG_X_OFFSET)) begin
        x_off_q <= cfg_data_i;
      end
      if (cfg_we_i && (cfg_index_i == REG_Y_OFFSET)) begin
        y_off_q <= cfg_data_i;
      end
    end
  end

  // Entry, pending and output payload registers
  always_ff @(posedge clk_i) begin
    if (expand) begin
      dbl_q    <= d_sw[18];
      flipx_q  <= a_sw[23];
      flipy_q  <= ~d_sw[17];
      zoomx_q  <= zoomx_in;
      zoomy_q  <= zoomy_in;
      tile_q   <= a_sw[14:0];
      prio_q   <= c_sw[19:18];
      colour_q <= c_sw[16:10];
      xb_q     <= x_base;
      yb_q     <= y_wrap;
    end
    if (st1_take && st1_adv) begin
      pend_code_q <= new_code;
      pend_sx_q   <= new_sx;
      pend_sy_q   <= new_sy;
      pend_w_q    <= new_w;
      pend_h_q    <= new_h;
    end
    if (out_load) begin
      out_code_q <= pend_code_q;
      out_pal_q  <= {1'b1, colour_q, 4'h0};
      out_mx_q   <= ~flipx_q;
      out_my_q   <= flipy_q;
      out_sx_q   <= pend_sx_q;
      out_sy_q   <= pend_sy_q;
      out_w_q    <= pend_w_q;
      out_h_q    <= pend_h_q;
      out_prio_q <= prio_mask(prio_q);
      out_last_q <= end_cond;
    end
  end

  // Result outputs
  assign out_valid_o     = out_vld_q;
  assign chunk_code_o    = out_code_q;
  assign palette_base_o  = out_pal_q;
  assign mirror_x_o      = out_mx_q;
  assign mirror_y_o      = out_my_q;
  assign screen_x_o      = out_sx_q;
  assign screen_y_o      = out_sy_q;
  assign chunk_width_o   = out_w_q;
  assign chunk_height_o  = out_h_q;
  assign priority_mask_o = out_prio_q;
  assign last_chunk_o    = out_last_q;

endmodule
`default_nettype wire
